// ===== src/wrfa_pkg.sv =====
// Shared types, constants and helper functions for the wall repulsion
// force accumulator. No dependencies; every other file imports this one.
package wrfa_pkg;

  // Field widths of the ports
  localparam int RANGE_W   = 16;
  localparam int ANGLE_W   = 16;
  localparam int STEP_W    = 15;
  localparam int FORCE_W   = 40;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  // Scan length limits
  localparam int MAX_BEAMS_DEF = 1024;
  localparam int IDX_MAX_W     = 12;   // index width of the longest allowed scan

  // Internal datapath widths
  localparam int ANG_W   = IDX_MAX_W + STEP_W + 1;  // beam angle, signed Q13
  localparam int RED_W   = 44;                      // angle in Q29, made non-negative
  localparam int MAG_W   = 32;                      // force magnitude, Q20.12
  localparam int TRIG_W  = 32;                      // CORDIC x / y, Q30
  localparam int Z_W     = 20;                      // residual angle, Q16
  localparam int PROD_W  = MAG_W + TRIG_W;
  localparam int D_W     = PROD_W - 30 + 2;         // signed per-beam contribution
  localparam int CNT_W   = 5;

  // Iteration counts
  localparam int DIV_STEPS    = 32;
  localparam int RED_STEPS    = 12;
  localparam int CORDIC_STEPS = 17;

  // Arithmetic constants
  localparam logic [RED_W-1:0]        TWO_PI29  = 44'd3373259426;
  localparam logic [RED_W-1:0]        TSH_INIT  = TWO_PI29 << (RED_STEPS - 1);
  localparam logic signed [RED_W:0]   PI29      = 45'sd1686629713;
  localparam logic signed [Z_W-1:0]   PI16      = 20'sd205887;
  localparam logic signed [Z_W-1:0]   HALF_PI16 = 20'sd102944;
  localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 32'sd652032874;
  localparam logic [MAG_W-1:0]        NEAR_MAG  = 32'd4096000000;
  localparam logic [RANGE_W-1:0]      NEAR_LIMIT = 16'd40;
  // upper 32 bits of 100 * 2^36, the starting partial remainder
  localparam logic [MAG_W-1:0]        DIV_REM0  = 32'd1600;

  // Register reset values
  localparam logic [ANGLE_W-1:0] MIN_ANGLE_RST  = 16'hCDBC;  // -12868
  localparam logic [STEP_W-1:0]  ANGLE_STEP_RST = '0;
  localparam logic [RANGE_W-1:0] MAX_RANGE_RST  = 16'hFFFF;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_ANGLE  = 2'd0,
    CFG_ANGLE_STEP = 2'd1,
    CFG_MAX_RANGE  = 2'd2
  } cfg_reg_t;

  // Arctangent table in Q16, one entry per CORDIC step
  function automatic logic signed [Z_W-1:0] atan_q16(input logic [CNT_W-1:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0:    v = 20'sd51472;
      5'd1:    v = 20'sd30386;
      5'd2:    v = 20'sd16055;
      5'd3:    v = 20'sd8150;
      5'd4:    v = 20'sd4091;
      5'd5:    v = 20'sd2047;
      5'd6:    v = 20'sd1024;
      5'd7:    v = 20'sd512;
      5'd8:    v = 20'sd256;
      5'd9:    v = 20'sd128;
      5'd10:   v = 20'sd64;
      5'd11:   v = 20'sd32;
      5'd12:   v = 20'sd16;
      5'd13:   v = 20'sd8;
      5'd14:   v = 20'sd4;
      5'd15:   v = 20'sd2;
      5'd16:   v = 20'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Add a contribution to a sum, clamping to the signed 40 bit range
  function automatic logic signed [FORCE_W-1:0] sat_add(
    input logic signed [FORCE_W-1:0] a,
    input logic signed [D_W-1:0]     b
  );
    logic signed [FORCE_W:0] s;
    s = {a[FORCE_W-1], a} + {{(FORCE_W + 1 - D_W){b[D_W-1]}}, b};
    if (s[FORCE_W] != s[FORCE_W-1]) begin
      return s[FORCE_W] ? {1'b1, {(FORCE_W-1){1'b0}}} : {1'b0, {(FORCE_W-1){1'b1}}};
    end
    return s[FORCE_W-1:0];
  endfunction

endpackage

// ===== src/wall_repulsion_force_accumulator_top.sv =====
// Wall repulsion force accumulator: beam sequencer, shared projection
// multiplier and saturating sums. Uses wrfa_pkg, wrfa_div and wrfa_angle.
//
//   port group | direction | handshake          | contents
//   in_*       | input     | in_valid/in_stall   | range_sample, last_reading
//   out_*      | output    | out_valid/out_stall | force_x, force_y
//   cfg_*      | input     | cfg_we              | cfg_index, cfg_data
//
// A reading at or above max_range goes straight to the final state; any other
// reading waits for the magnitude divider's 32 quotient bits, with the angle reduction
// and 17 CORDIC steps running beside it (at or below 0.01 m the divider is skipped).
// Reset is synchronous: it clears state, index, sums and out_valid.
// A last reading waits in its final cycle while an earlier word still
// sits unread in the output register; out_stall has no other effect.
module wall_repulsion_force_accumulator_top
  import wrfa_pkg::*;
#(
  parameter int MAX_BEAMS = MAX_BEAMS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [RANGE_W-1:0]        in_range_sample,
  input  logic                      in_last_reading,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [FORCE_W-1:0] out_force_x,
  output logic signed [FORCE_W-1:0] out_force_y,
  // configuration
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

  localparam int IW = $clog2(MAX_BEAMS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_START,
    ST_RUN,
    ST_PROJ_X,
    ST_PROJ_Y,
    ST_ACC_Y,
    ST_FIN
  } seq_state_t;

  seq_state_t                state_r;
  logic signed [ANGLE_W-1:0] min_angle_r;
  logic [STEP_W-1:0]         angle_step_r;
  logic [RANGE_W-1:0]        max_range_r;
  logic [IW-1:0]             idx_r;
  logic signed [FORCE_W-1:0] sum_x_r;
  logic signed [FORCE_W-1:0] sum_y_r;
  logic [RANGE_W-1:0]        range_r;
  logic                      last_r;
  logic signed [ANG_W-1:0]   ang_r;
  logic [2*RANGE_W-1:0]      rsq_r;
  logic [PROD_W-1:0]         prod_r;
  logic                      out_valid_r;
  logic signed [FORCE_W-1:0] out_x_r;
  logic signed [FORCE_W-1:0] out_y_r;

  logic                      accept;
  logic                      unit_start;
  logic                      div_busy;
  logic                      ang_busy;
  logic [MAG_W-1:0]          mag;
  logic signed [TRIG_W-1:0]  cos_v;
  logic signed [TRIG_W-1:0]  sin_v;
  logic signed [TRIG_W-1:0]  trig_sel;
  logic [TRIG_W-1:0]         trig_abs;
  logic [PROD_W-1:0]         prod_c;
  logic [PROD_W:0]           rnd;
  logic [D_W-1:0]            q_ext;
  logic signed [D_W-1:0]     dx;
  logic signed [D_W-1:0]     dy;
  logic [IDX_MAX_W+STEP_W-1:0] step_prod;
  logic signed [ANG_W-1:0]   ang_c;
  logic [IW-1:0]             idx_inc;
  logic                      out_free;
  logic                      emit;

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state_r != ST_IDLE);
  assign unit_start = (state_r == ST_START);
  assign out_free   = !out_valid_r || !out_stall;
  assign emit       = (state_r == ST_FIN) && last_r && out_free;

  // Beam angle: min_angle + index * angle_step
  assign step_prod = IDX_MAX_W'(idx_r) * angle_step_r;
  assign ang_c     = $signed({1'b0, step_prod})
                   + {{(ANG_W - ANGLE_W){min_angle_r[ANGLE_W-1]}}, min_angle_r};

  // Shared projection: magnitude times |cos| or |sin|, rounded half away
  assign trig_sel = (state_r == ST_PROJ_X) ? cos_v : sin_v;
  assign trig_abs = trig_sel[TRIG_W-1] ? TRIG_W'(-trig_sel) : TRIG_W'(trig_sel);
  assign prod_c   = mag * trig_abs;
  assign rnd      = {1'b0, prod_r} + ((PROD_W+1)'(1) << 29);
  assign q_ext    = {1'b0, rnd[PROD_W:30]};
  assign dx       = cos_v[TRIG_W-1] ? $signed(q_ext) : -$signed(q_ext);
  assign dy       = sin_v[TRIG_W-1] ? $signed(q_ext) : -$signed(q_ext);

  // Next beam index, wrapping at the scan length limit
  assign idx_inc = (idx_r == IW'(MAX_BEAMS - 1)) ? '0 : idx_r + 1'b1;

  wrfa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (unit_start),
    .r_sq  (rsq_r),
    .near  (range_r <= NEAR_LIMIT),
    .busy  (div_busy),
    .mag   (mag)
  );

  wrfa_angle u_angle (
    .clk   (clk),
    .rst_n (rst_n),
    .start (unit_start),
    .angle (ang_r),
    .busy  (ang_busy),
    .cos_o (cos_v),
    .sin_o (sin_v)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_angle_r  <= MIN_ANGLE_RST;
      angle_step_r <= ANGLE_STEP_RST;
      max_range_r  <= MAX_RANGE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_ANGLE:  min_angle_r  <= cfg_data;
        CFG_ANGLE_STEP: angle_step_r <= cfg_data[STEP_W-1:0];
        CFG_MAX_RANGE:  max_range_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, sums and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // load a finished scan's word, else drop the output word once taken
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            range_r <= in_range_sample;
            last_r  <= in_last_reading;
            state_r <= (in_range_sample >= max_range_r) ? ST_FIN : ST_SETUP;
          end
        end
        ST_SETUP: begin
          ang_r   <= ang_c;
          rsq_r   <= range_r * range_r;
          state_r <= ST_START;
        end
        ST_START: begin
          state_r <= ST_RUN;
        end
        ST_RUN: begin
          if (!div_busy && !ang_busy) begin
            state_r <= ST_PROJ_X;
          end
        end
        ST_PROJ_X: begin
          prod_r  <= prod_c;
          state_r <= ST_PROJ_Y;
        end
        ST_PROJ_Y: begin
          sum_x_r <= sat_add(sum_x_r, dx);
          prod_r  <= prod_c;
          state_r <= ST_ACC_Y;
        end
        ST_ACC_Y: begin
          sum_y_r <= sat_add(sum_y_r, dy);
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (!last_r) begin
            idx_r   <= idx_inc;
            state_r <= ST_IDLE;
          end else if (out_free) begin
            out_x_r     <= sum_x_r;
            out_y_r     <= sum_y_r;
            sum_x_r     <= '0;
            sum_y_r     <= '0;
            idx_r       <= '0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_force_x = out_x_r;
  assign out_force_y = out_y_r;

endmodule

// ===== src/wrfa_div.sv =====
// Restoring divider for the force magnitude 100 / r^2 in Q20.12.
// One quotient bit per cycle; depends on wrfa_pkg.
module wrfa_div
  import wrfa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [2*RANGE_W-1:0]   r_sq,
  input  logic                   near,
  output logic                   busy,
  output logic [MAG_W-1:0]       mag
);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [MAG_W-1:0] rem_r;
  logic [MAG_W-1:0] quo_r;
  logic [MAG_W-1:0] div_r;
  logic             near_r;

  logic [MAG_W:0]   trial;
  logic             ge;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_r, quo_r[MAG_W-1]};
  assign ge    = trial >= {1'b0, div_r};

  // Iterate: dividend is 100 * 2^36 + r^2 / 2, quotient fits 32 bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= ~near;
      cnt_r  <= CNT_W'(DIV_STEPS - 1);
      near_r <= near;
      div_r  <= r_sq;
      rem_r  <= DIV_REM0;
      quo_r  <= r_sq >> 1;
    end else if (busy_r) begin
      rem_r <= ge ? MAG_W'(trial - {1'b0, div_r}) : trial[MAG_W-1:0];
      quo_r <= {quo_r[MAG_W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign mag  = near_r ? NEAR_MAG : quo_r;

endmodule

// ===== src/wrfa_angle.sv =====
// Beam angle to cosine and sine: range reduction by repeated compare and
// subtract, quadrant fold, then one CORDIC rotation per cycle. Uses wrfa_pkg.
module wrfa_angle
  import wrfa_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [ANG_W-1:0]  angle,
  output logic                     busy,
  output logic signed [TRIG_W-1:0] cos_o,
  output logic signed [TRIG_W-1:0] sin_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RED,
    ST_FOLD,
    ST_ROT
  } ang_state_t;

  ang_state_t               state_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [RED_W-1:0]         v_r;
  logic [RED_W-1:0]         tsh_r;
  logic signed [Z_W-1:0]    z_r;
  logic signed [TRIG_W-1:0] x_r;
  logic signed [TRIG_W-1:0] y_r;
  logic                     neg_r;

  logic signed [RED_W:0]    u_c;
  logic signed [RED_W:0]    two_pi_s;
  logic signed [RED_W:0]    u_pos;
  logic [RED_W-1:0]         v_c;
  logic signed [Z_W-1:0]    zf;
  logic signed [TRIG_W-1:0] xs;
  logic signed [TRIG_W-1:0] ys;
  logic signed [Z_W-1:0]    at;

  // Scale to Q29 and shift by pi; one extra 2*pi makes it non-negative
  assign two_pi_s = $signed({1'b0, TWO_PI29});
  assign u_c      = $signed({angle[ANG_W-1], angle, 16'b0}) + PI29;
  assign u_pos    = u_c + two_pi_s;
  assign v_c      = u_c[RED_W] ? u_pos[RED_W-1:0] : u_c[RED_W-1:0];

  // Drop to Q16 and center on zero
  assign zf = $signed({1'b0, v_r[31:13]}) - PI16;

  // CORDIC step operands
  assign xs = x_r >>> cnt_r;
  assign ys = y_r >>> cnt_r;
  assign at = atan_q16(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            v_r     <= v_c;
            tsh_r   <= TSH_INIT;
            cnt_r   <= CNT_W'(RED_STEPS - 1);
            state_r <= ST_RED;
          end
        end
        // Subtract 2*pi times a falling power of two when it fits
        ST_RED: begin
          if (v_r >= tsh_r) begin
            v_r <= v_r - tsh_r;
          end
          tsh_r <= tsh_r >> 1;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= ST_FOLD;
          end
        end
        // Fold into [-pi/2, pi/2] and remember the sign flip
        ST_FOLD: begin
          if (zf > HALF_PI16) begin
            z_r   <= zf - PI16;
            neg_r <= 1'b1;
          end else if (zf < -HALF_PI16) begin
            z_r   <= zf + PI16;
            neg_r <= 1'b1;
          end else begin
            z_r   <= zf;
            neg_r <= 1'b0;
          end
          x_r     <= CORDIC_X0;
          y_r     <= '0;
          cnt_r   <= '0;
          state_r <= ST_ROT;
        end
        // Rotate toward the residual angle
        ST_ROT: begin
          if (z_r >= 0) begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - at;
          end else begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + at;
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy  = (state_r != ST_IDLE);
  assign cos_o = neg_r ? -x_r : x_r;
  assign sin_o = neg_r ? -y_r : y_r;

endmodule

// ===== src/wrfa_checker.sv =====
// Port-level checks for the wall repulsion force accumulator, attached to
// the top level by the bind below. Uses wrfa_pkg.
module wrfa_checker
  import wrfa_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [FORCE_W-1:0] out_force_x,
  input logic signed [FORCE_W-1:0] out_force_y
);

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_force_x) && $stable(out_force_y))
    else $error("output word changed while stalled");

  // Reset leaves the block empty and ready
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // Every accepted word makes the block busy in the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again without processing");

  // A result word only appears at the end of an item's work
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word appeared while idle");

endmodule

bind wall_repulsion_force_accumulator_top wrfa_checker u_wrfa_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_force_x (out_force_x),
  .out_force_y (out_force_y)
);

// ===== tb/wall_repulsion_force_accumulator_top_tb.sv =====
// Self-checking testbench for wall_repulsion_force_accumulator_top: a bit-exact
// force predictor, a result checker and named test tasks. Uses wrfa_pkg only.
module wall_repulsion_force_accumulator_top_tb;
  import wrfa_pkg::*;

  // Predictor constants
  localparam int          BEAMS          = 1024;
  localparam longint      HALF_TURN_Q29  = 64'sd1686629713;
  localparam longint      FULL_TURN_Q29  = 64'sd3373259426;
  localparam longint      PI_Q16         = 64'sd205887;
  localparam longint      HALF_PI_Q16    = 64'sd102944;
  localparam longint      CORDIC_GAIN_X0 = 64'sd652032874;
  localparam longint      NEAR_FORCE     = 64'sd4096000000;
  localparam longint      NEAR_RANGE     = 64'sd40;
  localparam longint      SUM_HI         = 64'sd549755813887;
  localparam longint      SUM_LO         = -64'sd549755813888;
  localparam logic [15:0] ANGLE_MAX      = 16'd25736;
  localparam logic [15:0] QUARTER_TURN   = 16'd12868;

  // Run control
  localparam int SETTLE_CYCLES = 48;
  localparam int HOLD_CYCLES   = 600;
  localparam int QUIET_LIMIT   = 5000;
  localparam int MAX_PRINTS    = 40;

  typedef struct {
    logic signed [FORCE_W-1:0] force_x;
    logic signed [FORCE_W-1:0] force_y;
  } force_pair_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [RANGE_W-1:0]        in_range_sample = '0;
  logic                      in_last_reading = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [FORCE_W-1:0] out_force_x;
  logic signed [FORCE_W-1:0] out_force_y;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = CFG_MIN_ANGLE;
  logic [CFG_W-1:0]          cfg_data = '0;

  // Predictor state, mirrors the block's registers and accumulators
  logic signed [ANGLE_W-1:0] min_angle_q = -16'sd12868;
  logic [STEP_W-1:0]         angle_step_q = '0;
  logic [RANGE_W-1:0]        max_range_q = 16'hFFFF;
  int                        beam_idx = 0;
  longint                    acc_x = 0;
  longint                    acc_y = 0;
  longint                    atan_table [17] = '{51472, 30386, 16055, 8150, 4091, 2047,
                                                 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
  force_pair_t               expected_forces [$];

  // Bookkeeping
  int error_count = 0;
  int readings_sent = 0;
  int scans_sent = 0;
  int results_checked = 0;
  int configs_done = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;
  int hold_ticket = 0;
  int hold_seen = 0;
  int hold_left = 0;

  wall_repulsion_force_accumulator_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_range_sample (in_range_sample),
    .in_last_reading (in_last_reading),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_force_x     (out_force_x),
    .out_force_y     (out_force_y),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Force predictor
  // ---------------------------------------------------------------------------

  // 100 / r^2 in Q20.12, rounded to nearest; fixed magnitude for very short reads
  function automatic longint repulsion_magnitude(input logic [RANGE_W-1:0] r);
    longint rsq;
    if (longint'(r) <= NEAR_RANGE) return NEAR_FORCE;
    rsq = longint'(r) * longint'(r);
    return ((longint'(100) << 36) + rsq / 2) / rsq;
  endfunction

  // Reduce the Q13 angle to [-pi/2, pi/2] and run the rotation-mode CORDIC
  function automatic void beam_cos_sin(input longint a13, output longint c,
                                       output longint s);
    longint m, z, x, y, xs, ys;
    bit flip;
    m = (a13 * 65536 + HALF_TURN_Q29) % FULL_TURN_Q29;
    if (m < 0) m += FULL_TURN_Q29;
    z = (m >>> 13) - PI_Q16;
    flip = 1'b0;
    if (z > HALF_PI_Q16) begin
      z -= PI_Q16;
      flip = 1'b1;
    end else if (z < -HALF_PI_Q16) begin
      z += PI_Q16;
      flip = 1'b1;
    end
    x = CORDIC_GAIN_X0;
    y = 0;
    for (int i = 0; i < 17; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= atan_table[i];
      end else begin
        x += ys;
        y -= xs;
        z += atan_table[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Force component pointing back at the sensor, rounded half away from zero
  function automatic longint repel_component(input longint mag, input longint trig);
    longint unsigned um, ut, p, q;
    um = mag;
    ut = (trig < 0) ? -trig : trig;
    p = um * ut;
    q = (p + 64'd536870912) >> 30;
    return (trig < 0) ? longint'(q) : -longint'(q);
  endfunction

  function automatic longint clamp_sum(input longint a, input longint b);
    longint t;
    t = a + b;
    if (t > SUM_HI) return SUM_HI;
    if (t < SUM_LO) return SUM_LO;
    return t;
  endfunction

  // Fold one accepted reading into the sums; queue the vector on the last beam
  function automatic void accumulate_reading(input logic [RANGE_W-1:0] r, input logic last);
    longint mag, angle, c, s;
    force_pair_t emitted;
    if (r < max_range_q) begin
      angle = longint'(min_angle_q) + longint'(beam_idx) * longint'(angle_step_q);
      mag = repulsion_magnitude(r);
      beam_cos_sin(angle, c, s);
      acc_x = clamp_sum(acc_x, repel_component(mag, c));
      acc_y = clamp_sum(acc_y, repel_component(mag, s));
    end
    beam_idx = (beam_idx + 1) % BEAMS;
    if (last) begin
      emitted.force_x = acc_x[FORCE_W-1:0];
      emitted.force_y = acc_y[FORCE_W-1:0];
      expected_forces.push_back(emitted);
      acc_x = 0;
      acc_y = 0;
      beam_idx = 0;
      scans_sent++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking, receiver and watchdog
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (error_count < MAX_PRINTS)
      $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Compare each accepted result word with the oldest expected vector
  always @(negedge clk) begin
    force_pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (expected_forces.size() == 0) begin
        report_mismatch("unexpected result word, force_x", out_force_x, 0);
      end else begin
        want = expected_forces.pop_front();
        if (out_force_x !== want.force_x)
          report_mismatch("force_x", out_force_x, want.force_x);
        if (out_force_y !== want.force_y)
          report_mismatch("force_y", out_force_y, want.force_y);
      end
    end
  end

  // Receiver: random stalls, long hold-off on request, none while calm
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 17);
    end
  end

  // Abort when nothing moves for too long
  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles at %0t", QUIET_LIMIT, $time);
        $display("wall_repulsion_force_accumulator_top verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one reading, sometimes after a random gap unless calm, and wait for acceptance
  task automatic send_reading(input logic [RANGE_W-1:0] r, input logic last);
    int gap;
    if (!calm && $urandom_range(99) < 17) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_range_sample <= r;
    in_last_reading <= last;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    accumulate_reading(r, last);
    readings_sent++;
  endtask

  // Mix of near, edge-of-range, ignored and fully random readings
  function automatic logic [RANGE_W-1:0] pick_reading();
    int lim;
    case ($urandom_range(9))
      0: return RANGE_W'($urandom_range(0, 40));
      1: return RANGE_W'($urandom_range(41, 400));
      2: begin
        lim = int'(max_range_q) - 2 + int'($urandom_range(0, 3));
        if (lim < 0) lim = 0;
        if (lim > 65535) lim = 65535;
        return RANGE_W'(lim);
      end
      3: return $urandom_range(0, 1) ? 16'hFFFF : 16'hFFFE;
      default: return RANGE_W'($urandom);
    endcase
  endfunction

  task automatic send_scan(input int beams);
    for (int k = 0; k < beams; k++)
      send_reading(pick_reading(), k == beams - 1);
  endtask

  // Drop valid and hold off until every expected vector has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_forces.size() != 0);
  endtask

  // Write all three registers while the block is idle
  task automatic configure(input logic [15:0] new_min_angle, input logic [15:0] new_step,
                           input logic [15:0] new_max_range);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIN_ANGLE;
    cfg_data  <= new_min_angle;
    @(posedge clk);
    cfg_index <= CFG_ANGLE_STEP;
    cfg_data  <= new_step;
    @(posedge clk);
    cfg_index <= CFG_MAX_RANGE;
    cfg_data  <= new_max_range;
    @(posedge clk);
    cfg_we <= 1'b0;
    min_angle_q  = new_min_angle;
    angle_step_q = new_step[STEP_W-1:0];
    max_range_q  = new_max_range;
    configs_done++;
  endtask

  // Change idling mode between posedges; valid must be low when called
  task automatic set_calm(input bit on);
    @(negedge clk);
    calm = on;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, near and ignored readings, odd angles, reset registers
  task automatic test_directed_extremes();
    send_reading(16'd0, 1'b1);
    send_reading(16'd40, 1'b1);
    send_reading(16'd41, 1'b1);
    send_reading(16'hFFFE, 1'b1);
    send_reading(16'hFFFF, 1'b1);
    send_reading(16'd1, 1'b0);
    send_reading(16'h8000, 1'b0);
    send_reading(16'h7FFF, 1'b1);
    // readings straddling max_range
    configure(QUARTER_TURN, 16'd6434, 16'd1000);
    send_reading(16'd999, 1'b0);
    send_reading(16'd1000, 1'b0);
    send_reading(16'd1001, 1'b0);
    send_reading(16'd500, 1'b1);
    // everything ignored
    configure(-ANGLE_MAX, ANGLE_MAX, 16'd0);
    send_reading(16'd0, 1'b0);
    send_reading(16'd12345, 1'b0);
    send_reading(16'hFFFF, 1'b1);
    // angles well outside [-pi, pi], step top bit masked off
    configure(16'h7FFF, 16'hFFFF, 16'd41);
    send_reading(16'd40, 1'b0);
    send_reading(16'd41, 1'b0);
    send_reading(16'd0, 1'b1);
  endtask

  // Drive both sums into both rails with long runs of very short readings
  // on two opposite diagonal headings
  task automatic test_saturation();
    logic [15:0] headings [2];
    headings = '{QUARTER_TURN >> 1, -(QUARTER_TURN + (QUARTER_TURN >> 1))};
    foreach (headings[h]) begin
      configure(headings[h], 16'd0, 16'hFFFF);
      for (int k = 0; k < 200; k++)
        send_reading((k % 2) ? 16'd0 : 16'd40, k == 199);
    end
  endtask

  // Scan longer than the beam limit so the index wraps
  task automatic test_index_wrap();
    configure(16'hFC18, 16'd25, 16'hFFFF);
    for (int k = 0; k < 1030; k++)
      send_reading((k < 4 || k >= 1018) ? RANGE_W'($urandom_range(41, 3000)) : 16'hFFFF,
                   k == 1029);
  endtask

  // Receiver holds off for a long stretch while short scans keep coming
  task automatic test_output_backpressure();
    configure(16'd3000, 16'd700, 16'hFFFF);
    @(negedge clk);
    hold_ticket++;
    @(posedge clk);
    for (int k = 0; k < 30; k++)
      send_scan($urandom_range(1, 3));
  endtask

  // Sender stops until all results are out, also partway through a scan
  task automatic test_sender_pause();
    configure(-QUARTER_TURN, 16'd1500, 16'd20000);
    for (int k = 0; k < 6; k++) begin
      send_reading(pick_reading(), 1'b0);
      send_reading(pick_reading(), 1'b0);
      drain_results();
      send_scan($urandom_range(1, 4));
      drain_results();
    end
  endtask

  // Random scans over several register settings, one phase without idling
  task automatic test_random_scans();
    logic [15:0] ma, st, mr;
    int sent, beams;
    for (int phase = 0; phase < 3; phase++) begin
      case ($urandom_range(3))
        0: ma = -ANGLE_MAX;
        1: ma = ANGLE_MAX;
        2: ma = 16'($signed($urandom_range(0, 51472)) - 25736);
        default: ma = 16'($urandom);
      endcase
      case ($urandom_range(3))
        0: st = 16'd0;
        1: st = ANGLE_MAX;
        2: st = 16'($urandom_range(0, 25736));
        default: st = 16'($urandom);
      endcase
      case ($urandom_range(7))
        0: mr = 16'd0;
        1, 2: mr = 16'hFFFF;
        3, 4: mr = 16'($urandom_range(41, 4000));
        default: mr = 16'($urandom);
      endcase
      if (phase == 0) begin
        ma = ANGLE_MAX;
        st = ANGLE_MAX;
        mr = 16'hFFFF;
      end else if (phase == 1) begin
        ma = -ANGLE_MAX;
        st = 16'd0;
        mr = 16'($urandom_range(41, 4000));
      end
      configure(ma, st, mr);
      set_calm(phase == 2);
      sent = 0;
      while (sent < 70) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: beams = $urandom_range(1, 8);
          6, 7, 8: beams = $urandom_range(9, 40);
          default: beams = $urandom_range(41, 120);
        endcase
        send_scan(beams);
        sent += beams;
      end
      if (phase == 2) begin
        drain_results();
        set_calm(1'b0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    test_saturation();
    test_index_wrap();
    test_output_backpressure();
    test_sender_pause();
    test_random_scans();

    // let the last scan drain, then allow for a trailing reading in flight
    drain_results();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (expected_forces.size() != 0)
      report_mismatch("force vectors never emitted", 0, expected_forces.size());

    $display("covered %0d readings in %0d scans under %0d register settings",
             readings_sent, scans_sent, configs_done);
    $display("checked %0d force vectors, %0d mismatches", results_checked, error_count);
    if (error_count == 0)
      $display("wall_repulsion_force_accumulator_top verification clean");
    else
      $display("wall_repulsion_force_accumulator_top verification failed");
    $finish;
  end

endmodule
